// ===== sv/chol_pkg.sv =====
// ----------------------------------------------------------------------------
// chol_pkg: shared types and constants of the Cholesky factorizer
// Sizes, status codes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package chol_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 24;
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int CELLS      = MAX_DIM * MAX_DIM;
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int SIZE_W     = 4;
   localparam int ACC_W      = 64;

   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [ADDR_W-1:0]            addr_type;
   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef logic [SIZE_W-1:0]            size_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOT_PD  = 2'd1,
      STATUS_ZERO_DG = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ENTRY,
      ST_RD_K,
      ST_WAIT_K,
      ST_MUL,
      ST_ACC,
      ST_FINISH,
      ST_SQRT,
      ST_DIV,
      ST_WRITE,
      ST_ERROR,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT
   } state_type;

   localparam acc_type ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam acc_type DATA_MAX = acc_type'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam acc_type DATA_MIN = -DATA_MAX - acc_type'(1);

   function automatic addr_type cell_addr(idx_type r, idx_type c);
      return {r, c};
   endfunction

   function automatic data_type sat_data(acc_type v);
      acc_type t;
      t = v;
      if (v > DATA_MAX) t = DATA_MAX;
      if (v < DATA_MIN) t = DATA_MIN;
      return t[DATA_WIDTH-1:0];
   endfunction

   function automatic acc_type add_sat(acc_type a, acc_type b);
      acc_type s;
      s = a + b;
      if (!a[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) s = ACC_MAX;
      if (a[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) s = ACC_MIN;
      return s;
   endfunction

   function automatic acc_type sub_sat(acc_type a, acc_type b);
      acc_type s;
      s = a - b;
      if (!a[ACC_W-1] && b[ACC_W-1] && s[ACC_W-1]) s = ACC_MAX;
      if (a[ACC_W-1] && !b[ACC_W-1] && !s[ACC_W-1]) s = ACC_MIN;
      return s;
   endfunction

endpackage

// ===== sv/chol_if.sv =====
// ----------------------------------------------------------------------------
// chol_req_if / chol_rsp_if: valid-ready channels of the factorizer
// Entry loads in, factor entries out.
// ----------------------------------------------------------------------------
interface chol_req_if;
   import chol_pkg::*;
   logic    valid;
   logic    ready;
   idx_type entry_row;
   idx_type entry_col;
   data_type entry_value;
   logic    load_done;
   modport source (output valid, entry_row, entry_col, entry_value, load_done,
                   input ready);
   modport sink   (input valid, entry_row, entry_col, entry_value, load_done,
                   output ready);
endinterface

interface chol_rsp_if;
   import chol_pkg::*;
   logic     valid;
   logic     ready;
   idx_type  factor_row;
   idx_type  factor_col;
   data_type factor_value;
   logic [1:0] status;
   logic     last_result;
   modport source (output valid, factor_row, factor_col, factor_value, status,
                   last_result, input ready);
   modport sink   (input valid, factor_row, factor_col, factor_value, status,
                   last_result, output ready);
endinterface

// ===== sv/chol_divroot.sv =====
// ----------------------------------------------------------------------------
// chol_divroot: shared multi-cycle divide and square-root unit
// Restoring signed 64/64 divide and bitwise 64-bit integer square root,
// one bit (divide) or one result bit (root) per cycle.
// ----------------------------------------------------------------------------
module chol_divroot (
   input  logic              clock,
   input  logic              reset,
   input  logic              start_div,
   input  logic              start_sqrt,
   input  chol_pkg::acc_type num,
   input  chol_pkg::acc_type den,
   output logic              busy,
   output logic              done,
   output chol_pkg::acc_type result
);
   import chol_pkg::*;

   localparam int CNT_W = $clog2(ACC_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                is_div_ff, is_div_in;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ACC_W-1:0]    rem_ff, rem_in;
   logic [ACC_W-1:0]    quo_ff, quo_in;
   logic [ACC_W-1:0]    den_ff, den_in;
   logic [ACC_W-1:0]    bit_ff, bit_in;
   logic [ACC_W:0]      trial;
   logic [ACC_W-1:0]    num_mag;
   logic [ACC_W-1:0]    den_mag;
   logic [ACC_W-1:0]    qs;

   assign num_mag = num[ACC_W-1] ? (~num + 1'b1) : num;
   assign den_mag = den[ACC_W-1] ? (~den + 1'b1) : den;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      bit_in    = bit_ff;
      trial     = '0;
      if (start_div) begin
         busy_in   = 1'b1;
         is_div_in = 1'b1;
         neg_in    = num[ACC_W-1] ^ den[ACC_W-1];
         cnt_in    = CNT_W'(ACC_W);
         rem_in    = '0;
         quo_in    = num_mag;
         den_in    = den_mag;
      end else if (start_sqrt) begin
         busy_in   = 1'b1;
         is_div_in = 1'b0;
         neg_in    = 1'b0;
         cnt_in    = CNT_W'(ACC_W / 2);
         rem_in    = num;
         quo_in    = '0;
         bit_in    = {2'b01, {(ACC_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (is_div_ff) begin
            trial = {rem_ff, quo_ff[ACC_W-1]} - {1'b0, den_ff};
            if (!trial[ACC_W]) begin
               rem_in = trial[ACC_W-1:0];
               quo_in = {quo_ff[ACC_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[ACC_W-2:0], quo_ff[ACC_W-1]};
               quo_in = {quo_ff[ACC_W-2:0], 1'b0};
            end
         end else begin
            trial = {1'b0, rem_ff} - {1'b0, (quo_ff + bit_ff)};
            if (!trial[ACC_W]) begin
               rem_in = trial[ACC_W-1:0];
               quo_in = (quo_ff >> 1) + bit_ff;
            end else begin
               quo_in = quo_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      bit_ff    <= bit_in;
   end

   assign qs     = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = qs;

endmodule

// ===== sv/cholesky_factorizer.sv =====
// ----------------------------------------------------------------------------
// cholesky_factorizer: fixed-point lower Cholesky factorization
// Loads a lower triangle, factors it, streams the factor out row by row.
// ----------------------------------------------------------------------------
// The transaction with load_done runs the factorization on one 32x32
// multiplier and one shared divide/root unit: each product of a dot product
// goes through a read of both operands, a read wait, the multiply and the
// accumulate, and each entry then takes a diagonal root or an off-diagonal
// divide plus setup and write-back. Each result is then read, waited on and
// output. The block accepts no transaction until the last result is taken.
// Memories start undefined; no clearing pass is run.
module cholesky_factorizer (
   input  logic                clock,
   input  logic                reset,
   chol_req_if.sink            req,
   chol_rsp_if.source          rsp,
   input  logic                csr_we,
   input  chol_pkg::size_type  csr_wdata
);
   import chol_pkg::*;

   data_type  a_mem [CELLS];
   data_type  l_mem [CELLS];

   state_type state_ff, state_in;
   size_type  size_ff;
   idx_type   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   acc_type   s_ff, s_in;
   acc_type   prod_ff;
   data_type  la_ff, lb_ff, a_rd_ff;
   acc_type   num_ff, num_in;
   data_type  res_ff, res_in;
   logic      rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic      rsp_last_ff, rsp_last_in;
   idx_type   rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   data_type  rsp_val_ff, rsp_val_in;

   addr_type  ra_addr, rb_addr;
   logic      l_we;
   logic      start_div, start_sqrt, du_busy, du_done;
   acc_type   du_num, du_den, du_res;
   acc_type   a_scaled, diff, pivot;
   idx_type   last_idx;
   logic      a_we;

   assign last_idx = idx_type'(size_ff - 1'b1);
   assign a_we = req.valid && req.ready && (req.entry_col <= req.entry_row);
   assign a_scaled = acc_type'(a_rd_ff) <<< FRAC_BITS;
   assign diff = sub_sat(a_scaled, s_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= size_type'(MAX_DIM);
      end else if (csr_we) begin
         if (csr_wdata == '0)
            size_ff <= size_type'(1);
         else if (csr_wdata > size_type'(MAX_DIM))
            size_ff <= size_type'(MAX_DIM);
         else
            size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) a_mem[cell_addr(req.entry_row, req.entry_col)] <= req.entry_value;
      a_rd_ff <= a_mem[cell_addr(i_ff, j_ff)];
      if (l_we) l_mem[cell_addr(i_ff, j_ff)] <= res_ff;
      la_ff <= l_mem[ra_addr];
      lb_ff <= l_mem[rb_addr];
      prod_ff <= acc_type'(la_ff) * acc_type'(lb_ff);
   end

   chol_divroot u_divroot (
      .clock      (clock),
      .reset      (reset),
      .start_div  (start_div),
      .start_sqrt (start_sqrt),
      .num        (du_num),
      .den        (du_den),
      .busy       (du_busy),
      .done       (du_done),
      .result     (du_res)
   );

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      s_in          = s_ff;
      num_in        = num_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_val_in    = rsp_val_ff;
      ra_addr       = cell_addr(i_ff, k_ff);
      rb_addr       = cell_addr(j_ff, k_ff);
      l_we          = 1'b0;
      start_div     = 1'b0;
      start_sqrt    = 1'b0;
      du_num        = num_ff;
      du_den        = '0;
      pivot         = acc_type'(lb_ff);
      req.ready     = 1'b0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req.ready = !rsp_valid_ff;
            if (req.valid && !rsp_valid_ff && req.load_done) begin
               i_in = '0;
               j_in = '0;
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: begin
            s_in = '0;
            k_in = '0;
            state_in = (j_ff == '0) ? ST_FINISH : ST_RD_K;
         end
         ST_RD_K:   state_in = ST_WAIT_K;
         ST_WAIT_K: state_in = ST_MUL;
         ST_MUL:    state_in = ST_ACC;
         ST_ACC: begin
            s_in = add_sat(s_ff, prod_ff);
            k_in = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == j_ff) ? ST_FINISH : ST_RD_K;
         end
         ST_FINISH: begin
            ra_addr = cell_addr(j_ff, j_ff);
            rb_addr = cell_addr(j_ff, j_ff);
            num_in = diff;
            if (i_ff == j_ff) begin
               if (diff <= 0) begin
                  rsp_status_in = STATUS_NOT_PD;
                  state_in = ST_ERROR;
               end else begin
                  du_num = acc_type'(sat_data(diff >>> FRAC_BITS)) <<< FRAC_BITS;
                  start_sqrt = 1'b1;
                  state_in = ST_SQRT;
               end
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_SQRT: begin
            if (du_done) begin
               res_in = sat_data(du_res);
               if (sat_data(du_res) == '0) begin
                  rsp_status_in = STATUS_ZERO_DG;
                  state_in = ST_ERROR;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_DIV: begin
            if (!du_busy && !du_done) begin
               if (lb_ff <= 0) pivot = acc_type'(1);
               du_den = pivot;
               start_div = 1'b1;
            end else if (du_done) begin
               res_in = sat_data(du_res);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            l_we = 1'b1;
            if (j_ff == i_ff) begin
               j_in = '0;
               if (i_ff == last_idx) begin
                  i_in = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = ST_ENTRY;
               end
            end else begin
               j_in = j_ff + 1'b1;
               state_in = ST_ENTRY;
            end
         end
         ST_ERROR: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = i_ff;
               rsp_col_in   = '0;
               rsp_val_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         ST_OUT_RD: begin
            ra_addr = cell_addr(i_ff, j_ff);
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            ra_addr = cell_addr(i_ff, j_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            ra_addr = cell_addr(i_ff, j_ff);
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = i_ff;
               rsp_col_in    = j_ff;
               rsp_val_in    = la_ff;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = (i_ff == last_idx) && (j_ff == i_ff);
               if (j_ff == i_ff) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
                  state_in = (i_ff == last_idx) ? ST_LOAD : ST_OUT_RD;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      s_ff          <= s_in;
      num_ff        <= num_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_val_ff    <= rsp_val_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.factor_row   = rsp_row_ff;
   assign rsp.factor_col   = rsp_col_ff;
   assign rsp.factor_value = rsp_val_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.last_result  = rsp_last_ff;

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (state_ff == ST_LOAD && !rsp_valid_ff))
      else $error("ready outside load state");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != STATUS_OK) |-> rsp.last_result)
      else $error("error result not marked last");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.factor_value == '0))
      else $error("error result has nonzero value");
   a_unit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !du_busy)
      else $error("divide unit busy while loading");
`endif

endmodule
